@@ rtl/core/ifsc_pkg.sv @@
// shared types, constants and tables for the ir follow speed controller
// no dependencies; imported by every module of the block
package ifsc_pkg;

    localparam int CORDIC_STEPS_DEF = 14;
    localparam int DIST_BITS_DEF    = 12;
    localparam int ANGLE_BITS       = 18;
    localparam int CMD_BITS         = 14;
    localparam int STEP_BITS        = 13;
    localparam int GAIN_BITS        = 16;
    localparam int SIDE_BITS        = 6;
    localparam int INV_GAIN_Q16     = 39797;

    localparam int RST_CLAMP  = 1760;
    localparam int RST_DETECT = 1680;
    localparam int RST_FOLLOW = 880;
    localparam int RST_GAIN   = 3932;
    localparam int RST_SSTEP  = 410;
    localparam int RST_TSTEP  = 410;
    localparam int RST_SCAP   = 2048;
    localparam int RST_TCAP   = 6144;

    // register indexes on the config port
    localparam logic [2:0] REG_CLAMP  = 3'd0;
    localparam logic [2:0] REG_DETECT = 3'd1;
    localparam logic [2:0] REG_FOLLOW = 3'd2;
    localparam logic [2:0] REG_GAIN   = 3'd3;
    localparam logic [2:0] REG_SSTEP  = 3'd4;
    localparam logic [2:0] REG_TSTEP  = 3'd5;
    localparam logic [2:0] REG_SCAP   = 3'd6;
    localparam logic [2:0] REG_TCAP   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ITER,
        ST_RANGE,
        ST_LIN,
        ST_SLEW,
        ST_CAP
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic iter;
        logic range_mul;
        logic lin_mul;
        logic slew;
        logic commit;
    } dp_cmd_t;

    // atan(2^-i) in radians q.16
    function automatic logic [16:0] atan_q16(input logic [4:0] idx);
        logic [16:0] v;
        begin
            unique case (idx)
                5'd0:  v = 17'd51472;
                5'd1:  v = 17'd30385;
                5'd2:  v = 17'd16055;
                5'd3:  v = 17'd8150;
                5'd4:  v = 17'd4091;
                5'd5:  v = 17'd2047;
                5'd6:  v = 17'd1024;
                5'd7:  v = 17'd512;
                5'd8:  v = 17'd256;
                5'd9:  v = 17'd128;
                5'd10: v = 17'd64;
                5'd11: v = 17'd32;
                5'd12: v = 17'd16;
                5'd13: v = 17'd8;
                5'd14: v = 17'd4;
                5'd15: v = 17'd2;
                5'd16: v = 17'd1;
                5'd17: v = 17'd1;
                default: v = 17'd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/core/ifsc_ctrl.sv @@
// sequencer for the ir follow speed controller: steps one item through the datapath
// depends on ifsc_pkg
module ifsc_ctrl
    import ifsc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output dp_cmd_t                           cmd,
    output logic [$clog2(CORDIC_STEPS)-1:0]   iter_idx
);

    localparam int IW = $clog2(CORDIC_STEPS);

    ctrl_state_t   state_reg, state_next;
    logic [IW-1:0] iter_cnt_reg, iter_cnt_next;
    logic          out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_cnt_reg  <= iter_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        iter_cnt_next  = iter_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load      = 1'b1;
                iter_cnt_next = '0;
                state_next    = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.iter      = 1'b1;
                iter_cnt_next = iter_cnt_reg + 1'b1;
                if (iter_cnt_reg == IW'(CORDIC_STEPS - 1))
                begin
                    iter_cnt_next = '0;
                    state_next    = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                cmd.range_mul = 1'b1;
                state_next    = ST_LIN;
            end
            ST_LIN:
            begin
                cmd.lin_mul = 1'b1;
                state_next  = ST_SLEW;
            end
            ST_SLEW:
            begin
                cmd.slew   = 1'b1;
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                // wait for the output slot to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign iter_idx  = iter_cnt_reg;

    a_commit_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (state_reg == ST_CAP))
        else $error("commit outside cap state");
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit would overwrite a pending beat");
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_LOAD))
        else $error("accepted beat not loaded");
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER) |-> (iter_cnt_reg <= IW'(CORDIC_STEPS - 1)))
        else $error("iteration counter out of range");

endmodule

@@ rtl/core/ifsc_datapath.sv @@
// datapath of the ir follow speed controller: target pick, cordic, gains, slew and cap
// depends on ifsc_pkg; driven by ifsc_ctrl commands
module ifsc_datapath
    import ifsc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int DIST_BITS    = DIST_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dp_cmd_t                         cmd,
    input  logic [$clog2(CORDIC_STEPS)-1:0] iter_idx,
    input  logic [DIST_BITS-1:0]            dist_left,
    input  logic [DIST_BITS-1:0]            dist_centre,
    input  logic [DIST_BITS-1:0]            dist_right,
    input  logic [DIST_BITS-1:0]            clamp_distance,
    input  logic [DIST_BITS-1:0]            detect_range,
    input  logic [DIST_BITS-1:0]            follow_distance,
    input  logic [GAIN_BITS-1:0]            speed_gain,
    input  logic [STEP_BITS-1:0]            speed_step,
    input  logic [STEP_BITS-1:0]            turn_step,
    input  logic [STEP_BITS-1:0]            speed_cap,
    input  logic [STEP_BITS-1:0]            turn_cap,
    output logic signed [CMD_BITS-1:0]      linear_cmd,
    output logic signed [CMD_BITS-1:0]      angular_cmd
);

    localparam int DB = DIST_BITS;
    localparam int XW = DIST_BITS + 10;
    localparam int ZW = ANGLE_BITS;
    localparam int RW = XW + 17;
    localparam int PW = XW + 18;
    localparam int LW = XW + 2;
    localparam int LDW = LW + 1;
    localparam int AW = ZW - 2;
    localparam int ADW = AW + 1;

    logic [DB-1:0]        in_l_reg, in_c_reg, in_r_reg;
    logic [DB-1:0]        ahead_reg;
    logic signed [SIDE_BITS-1:0] side_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic                 zero_reg;
    logic signed [RW-1:0] rprod_reg;
    logic signed [PW-1:0] lprod_reg;
    logic signed [CMD_BITS-1:0] dlin_reg, dang_reg;
    logic signed [CMD_BITS-1:0] last_lin_reg, last_ang_reg;

    // clamp and classify
    logic [DB-1:0] rl, rc, rr;
    logic          nl, nc, nr, fl, fc, fr;
    logic [DB:0]   sum_lc, sum_cr;
    logic [DB-1:0] ahead_next;
    logic signed [SIDE_BITS-1:0] side_next;
    logic          hit;

    always_comb
    begin
        rl = (in_l_reg > clamp_distance) ? clamp_distance : in_l_reg;
        rc = (in_c_reg > clamp_distance) ? clamp_distance : in_c_reg;
        rr = (in_r_reg > clamp_distance) ? clamp_distance : in_r_reg;
        nl = rl < detect_range;
        nc = rc < detect_range;
        nr = rr < detect_range;
        fl = rl > detect_range;
        fc = rc > detect_range;
        fr = rr > detect_range;
        sum_lc = {1'b0, rl} + {1'b0, rc};
        sum_cr = {1'b0, rc} + {1'b0, rr};
        hit        = 1'b1;
        ahead_next = ahead_reg;
        side_next  = side_reg;
        if (fl && fc && fr)
        begin
            ahead_next = follow_distance;
            side_next  = 6'sd0;
        end
        else if (nl && fc && fr)
        begin
            ahead_next = rl;
            side_next  = 6'sd20;
        end
        else if (nl && nc && fr)
        begin
            ahead_next = sum_lc[DB:1];
            side_next  = 6'sd10;
        end
        else if (nl && nc && nr)
        begin
            ahead_next = rc;
            side_next  = 6'sd0;
        end
        else if (fl && nc && nr)
        begin
            ahead_next = sum_cr[DB:1];
            side_next  = -6'sd10;
        end
        else if (fl && fc && nr)
        begin
            ahead_next = rr;
            side_next  = -6'sd20;
        end
        else
        begin
            hit = 1'b0;
        end
    end

    // one cordic micro-rotation
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] ang_step;

    always_comb
    begin
        xs       = x_reg >>> iter_idx;
        ys       = y_reg >>> iter_idx;
        ang_step = $signed({1'b0, atan_q16(5'(iter_idx))});
    end

    // linear gain input
    logic signed [XW-1:0]  range_q12;
    logic signed [XW:0]    lin_err;

    always_comb
    begin
        range_q12 = rprod_reg[XW+15:16];
        lin_err   = $signed({range_q12[XW-1], range_q12})
                  - $signed({3'b000, follow_distance, 8'h00});
    end

    // slew limit
    logic signed [LW-1:0]  lin_tgt;
    logic signed [AW-1:0]  ang_tgt;
    logic signed [LDW-1:0] lin_d, lin_sl;
    logic signed [ADW-1:0] ang_d, ang_sl;

    always_comb
    begin
        lin_tgt = lprod_reg[XW+17:16];
        ang_tgt = z_reg[ZW-1:2];
        lin_d   = LDW'(lin_tgt) - LDW'(last_lin_reg);
        ang_d   = ADW'(ang_tgt) - ADW'(last_ang_reg);
        lin_sl  = $signed(LDW'({1'b0, speed_step}));
        ang_sl  = $signed(ADW'({1'b0, turn_step}));
    end

    // magnitude cap
    logic signed [CMD_BITS:0] lin_sum, ang_sum, lin_cp, ang_cp;

    always_comb
    begin
        lin_sum = (CMD_BITS+1)'(last_lin_reg) + (CMD_BITS+1)'(dlin_reg);
        ang_sum = (CMD_BITS+1)'(last_ang_reg) + (CMD_BITS+1)'(dang_reg);
        lin_cp  = $signed({2'b00, speed_cap});
        ang_cp  = $signed({2'b00, turn_cap});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahead_reg    <= DB'(RST_FOLLOW);
            side_reg     <= '0;
            last_lin_reg <= '0;
            last_ang_reg <= '0;
        end
        else
        begin
            if (cmd.load && hit)
            begin
                ahead_reg <= ahead_next;
                side_reg  <= side_next;
            end
            if (cmd.commit)
            begin
                if (lin_sum >= lin_cp)
                    last_lin_reg <= CMD_BITS'(lin_cp);
                else if (lin_sum <= -lin_cp)
                    last_lin_reg <= CMD_BITS'(-lin_cp);
                else
                    last_lin_reg <= CMD_BITS'(lin_sum);
                if (ang_sum >= ang_cp)
                    last_ang_reg <= CMD_BITS'(ang_cp);
                else if (ang_sum <= -ang_cp)
                    last_ang_reg <= CMD_BITS'(-ang_cp);
                else
                    last_ang_reg <= CMD_BITS'(ang_sum);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_l_reg <= dist_left;
            in_c_reg <= dist_centre;
            in_r_reg <= dist_right;
        end
        if (cmd.load)
        begin
            x_reg    <= $signed({2'b00, ahead_next, 8'h00});
            y_reg    <= $signed({{(XW-SIDE_BITS-12){side_next[SIDE_BITS-1]}}, side_next, 12'h000});
            z_reg    <= '0;
            zero_reg <= (ahead_next == '0) && (side_next == '0);
        end
        if (cmd.iter && !zero_reg)
        begin
            if (!y_reg[XW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang_step;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang_step;
            end
        end
        if (cmd.range_mul)
        begin
            if (zero_reg)
                rprod_reg <= '0;
            else
                rprod_reg <= RW'(x_reg * $signed(17'(INV_GAIN_Q16)));
        end
        if (cmd.lin_mul)
        begin
            lprod_reg <= PW'($signed({1'b0, speed_gain}) * lin_err);
        end
        if (cmd.slew)
        begin
            if (lin_d >= lin_sl)
                dlin_reg <= CMD_BITS'(lin_sl);
            else if (lin_d <= -lin_sl)
                dlin_reg <= CMD_BITS'(-lin_sl);
            else
                dlin_reg <= CMD_BITS'(lin_d);
            if (ang_d >= ang_sl)
                dang_reg <= CMD_BITS'(ang_sl);
            else if (ang_d <= -ang_sl)
                dang_reg <= CMD_BITS'(-ang_sl);
            else
                dang_reg <= CMD_BITS'(ang_d);
        end
    end

    assign linear_cmd  = last_lin_reg;
    assign angular_cmd = last_ang_reg;

endmodule

@@ rtl/core/ir_follow_speed_controller_unit.sv @@
// top level of the ir follow speed controller: stream ports, apb register file
// depends on ifsc_pkg, ifsc_ctrl, ifsc_datapath
// a beat is captured in idle, then passes load, the shared cordic loop, range, lin, slew
// and cap, where it waits for a free output slot; a new input beat is taken only in idle
// a finished beat waits in the output register while the next input beat is taken
// reset (rst_n low, async): registers to defaults, target 880 ahead / 0 side, last commands 0
module ir_follow_speed_controller_unit
    import ifsc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int DIST_BITS    = DIST_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // dist_left, dist_centre, dist_right from bit 0 up, zero padded
    input  logic [((3*DIST_BITS+7)/8)*8-1:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // linear_cmd [13:0], angular_cmd [27:14], zero padded
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DB = DIST_BITS;
    localparam int IW = $clog2(CORDIC_STEPS);

    // configuration registers
    logic [DB-1:0]        clamp_reg, detect_reg, follow_reg;
    logic [GAIN_BITS-1:0] gain_reg;
    logic [STEP_BITS-1:0] sstep_reg, tstep_reg, scap_reg, tcap_reg;
    logic [2:0]           reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg  <= DB'(RST_CLAMP);
            detect_reg <= DB'(RST_DETECT);
            follow_reg <= DB'(RST_FOLLOW);
            gain_reg   <= GAIN_BITS'(RST_GAIN);
            sstep_reg  <= STEP_BITS'(RST_SSTEP);
            tstep_reg  <= STEP_BITS'(RST_TSTEP);
            scap_reg   <= STEP_BITS'(RST_SCAP);
            tcap_reg   <= STEP_BITS'(RST_TCAP);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CLAMP:  clamp_reg  <= pwdata[DB-1:0];
                REG_DETECT: detect_reg <= pwdata[DB-1:0];
                REG_FOLLOW: follow_reg <= pwdata[DB-1:0];
                REG_GAIN:   gain_reg   <= pwdata[GAIN_BITS-1:0];
                REG_SSTEP:  sstep_reg  <= pwdata[STEP_BITS-1:0];
                REG_TSTEP:  tstep_reg  <= pwdata[STEP_BITS-1:0];
                REG_SCAP:   scap_reg   <= pwdata[STEP_BITS-1:0];
                REG_TCAP:   tcap_reg   <= pwdata[STEP_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_CLAMP:  prdata = 32'(clamp_reg);
            REG_DETECT: prdata = 32'(detect_reg);
            REG_FOLLOW: prdata = 32'(follow_reg);
            REG_GAIN:   prdata = 32'(gain_reg);
            REG_SSTEP:  prdata = 32'(sstep_reg);
            REG_TSTEP:  prdata = 32'(tstep_reg);
            REG_SCAP:   prdata = 32'(scap_reg);
            REG_TCAP:   prdata = 32'(tcap_reg);
            default:    prdata = '0;
        endcase
    end

    // sequencer and datapath
    dp_cmd_t                    cmd;
    logic [IW-1:0]              iter_idx;
    logic signed [CMD_BITS-1:0] linear_cmd, angular_cmd;

    ifsc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .iter_idx  (iter_idx)
    );

    ifsc_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .DIST_BITS    (DIST_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .iter_idx        (iter_idx),
        .dist_left       (s_tdata[DB-1:0]),
        .dist_centre     (s_tdata[2*DB-1:DB]),
        .dist_right      (s_tdata[3*DB-1:2*DB]),
        .clamp_distance  (clamp_reg),
        .detect_range    (detect_reg),
        .follow_distance (follow_reg),
        .speed_gain      (gain_reg),
        .speed_step      (sstep_reg),
        .turn_step       (tstep_reg),
        .speed_cap       (scap_reg),
        .turn_cap        (tcap_reg),
        .linear_cmd      (linear_cmd),
        .angular_cmd     (angular_cmd)
    );

    // output beat comes straight from the last-command registers
    assign m_tdata = {4'h0, angular_cmd, linear_cmd};

endmodule
